// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and codes for the double-ended queue
// Payload structs, operation and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam logic [2:0] F_PUSH_FRONT = 3'd0;
    localparam logic [2:0] F_POP_FRONT  = 3'd1;
    localparam logic [2:0] F_PUSH_REAR  = 3'd2;
    localparam logic [2:0] F_POP_REAR   = 3'd3;
    localparam logic [2:0] F_LIST       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value_in;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [1:0]         status;
        logic               last;
        logic [4:0]         occupancy;
    } t_out;

    typedef struct packed {
        logic load;
        logic push;
        logic err;
        logic rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_func_ok;
        logic is_push;
        logic full;
        logic empty;
        logic more;
    } t_stat;

endpackage

// ===== design/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl: operation sequencer
// Takes one beat at a time and steps the datapath through execute, read
// (pop or list with entries) and output phases, once per entry of a list.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_stall,
    input  deq_pkg::t_stat i_stat,
    output deq_pkg::t_cmd  o_cmd,
    output logic           o_in_stall,
    output logic           o_out_valid
);
    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   w_accept;

    assign w_accept    = (r_state == S_IDLE) && i_in_valid && !r_in_stall;
    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = w_accept;
        case (r_state)
            S_EXEC: begin
                o_cmd.err  = i_stat.is_push ? i_stat.full : i_stat.empty;
                o_cmd.push = i_stat.is_push && !i_stat.full;
                o_cmd.rd   = !i_stat.is_push && !i_stat.empty;
            end
            S_READ: begin
                o_cmd.emit = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_stat.in_func_ok) begin
                        r_state    <= S_EXEC;
                        r_in_stall <= 1'b1;
                    end
                end
                S_EXEC: begin
                    if (o_cmd.rd) begin
                        r_state <= S_READ;
                    end else begin
                        r_state     <= S_OUT;
                        r_out_valid <= 1'b1;
                    end
                end
                S_READ: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (i_stat.more) begin
                            r_state <= S_EXEC;
                        end else begin
                            r_state    <= S_IDLE;
                            r_in_stall <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/deq_dpath.sv =====
// ----------------------------------------------------------------------------
// deq_dpath: ring buffer datapath
// Entry memory, head pointer, entry count, list index and result register.
// ----------------------------------------------------------------------------
module deq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  deq_pkg::t_in   i_in_data,
    input  deq_pkg::t_cmd  i_cmd,
    output deq_pkg::t_stat o_stat,
    output deq_pkg::t_out  o_out_data
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] mem [DEPTH];

    logic [AW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [2:0]         r_func;
    logic signed [31:0] r_val;
    logic [AW-1:0]      r_idx;
    logic signed [31:0] r_rdata;
    t_out               r_out;

    logic          w_front;
    logic          w_push;
    logic          w_pop;
    logic          w_list_last;
    logic [AW-1:0] w_head_dec;
    logic [AW-1:0] w_head_inc;
    logic [AW:0]   w_wr_sum;
    logic [AW-1:0] w_wr_slot;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_off;
    logic [AW:0]   w_rd_sum;
    logic [AW-1:0] w_rd_addr;

    assign w_push  = (r_func == F_PUSH_FRONT) || (r_func == F_PUSH_REAR);
    assign w_pop   = (r_func == F_POP_FRONT) || (r_func == F_POP_REAR);
    assign w_front = (r_func == F_PUSH_FRONT) || (r_func == F_POP_FRONT);
    assign w_list_last = ((CW'(r_idx) + CW'(1)) == r_count);

    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign w_head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    assign w_wr_sum  = {1'b0, r_head} + {1'b0, AW'(r_count)};
    assign w_wr_slot = (w_wr_sum >= (AW+1)'(DEPTH)) ? AW'(w_wr_sum - (AW+1)'(DEPTH))
                                                      : AW'(w_wr_sum);
    assign w_wr_addr = w_front ? w_head_dec : w_wr_slot;

    always_comb begin
        case (r_func)
            F_POP_FRONT: w_rd_off = '0;
            F_POP_REAR:  w_rd_off = AW'(r_count - CW'(1));
            default:     w_rd_off = r_idx;
        endcase
    end

    assign w_rd_sum  = {1'b0, r_head} + {1'b0, w_rd_off};
    assign w_rd_addr = (w_rd_sum >= (AW+1)'(DEPTH)) ? AW'(w_rd_sum - (AW+1)'(DEPTH))
                                                      : AW'(w_rd_sum);

    assign o_stat.in_func_ok = (i_in_data.func <= F_LIST);
    assign o_stat.is_push    = w_push;
    assign o_stat.full       = (r_count == CW'(DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.more       = !r_out.last;
    assign o_out_data        = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[w_wr_addr] <= r_val;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_in_data.func;
            r_val  <= i_in_data.value_in;
            r_idx  <= '0;
        end
        if (i_cmd.err) begin
            r_out.value_out <= '0;
            r_out.status    <= w_push ? ST_FULL : ST_EMPTY;
            r_out.last      <= 1'b1;
            r_out.occupancy <= 5'(r_count);
        end
        if (i_cmd.push) begin
            r_out.value_out <= '0;
            r_out.status    <= ST_OK;
            r_out.last      <= 1'b1;
            r_out.occupancy <= 5'(r_count + CW'(1));
        end
        if (i_cmd.emit) begin
            r_out.value_out <= r_rdata;
            r_out.status    <= ST_OK;
            r_out.last      <= w_pop || w_list_last;
            r_out.occupancy <= w_pop ? 5'(r_count - CW'(1)) : 5'(r_count);
            if (!w_pop) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
                if (w_front) begin
                    r_head <= w_head_dec;
                end
            end
            if (i_cmd.emit && w_pop) begin
                r_count <= r_count - CW'(1);
                if (w_front) begin
                    r_head <= w_head_inc;
                end
            end
        end
    end

endmodule

// ===== design/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: ring-buffer deque of 32-bit signed job IDs
// Push/pop at either end, or list all entries front to rear.
// ----------------------------------------------------------------------------
// One beat is taken at a time. The sequencer steps each item through
// execute, a registered single-port memory read (only for a pop or list that
// finds entries) and the output register, and repeats these steps for each
// entry of a list; a stalled output holds the next accept off. The entry
// memory needs no clearing after reset. Occupancy reports the low five bits
// of the entry count.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  deq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output deq_pkg::t_out o_out_data
);
    import deq_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for double_ended_queue
// Drives push, pop and list beats through the input channel. A shadow ring
// buffer predicts every result beat, and the result beats are compared in
// order. The run covers an empty and a full queue, extreme job IDs, ignored
// codes and several idle and stall mixes. It also holds the output off for
// a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import deq_pkg::*;

    localparam int         QUEUE_DEPTH     = 16;
    localparam logic [2:0] F_SPARE_FIRST   = 3'd5;
    localparam logic [2:0] F_SPARE_LAST    = 3'd7;
    localparam int         STALL_LIMIT     = 2000;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         DRAIN_CYCLES    = 64;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    logic signed [31:0] shadow_slot [QUEUE_DEPTH];
    logic [3:0]         shadow_head;
    logic [4:0]         shadow_count;
    t_out               deque_replies [$];

    int   send_idle_pct;
    int   recv_stall_pct;
    bit   long_hold;
    event hold_off_start;

    int mismatches;
    int ops_sent;
    int beats_checked;
    int refused_pushes;
    int empty_answers;
    int idle_cycles;

    double_ended_queue #(.DEPTH(QUEUE_DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        forever begin
            @(hold_off_start);
            @(negedge i_clk);
            long_hold = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            long_hold = 1'b0;
        end
    end

    task automatic note_mismatch(input string why, input t_out want, input t_out got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s): expected value %0d status %0d last %0b occupancy %0d,",
                     why, want.value_out, want.status, want.last, want.occupancy);
            $display("    got value %0d status %0d last %0b occupancy %0d",
                     got.value_out, got.status, got.last, got.occupancy);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_checked++;
            if (deque_replies.size() == 0) begin
                note_mismatch("beat with nothing outstanding", '0, o_out_data);
            end else begin
                want = deque_replies.pop_front();
                if (o_out_data.value_out !== want.value_out ||
                    o_out_data.status !== want.status ||
                    o_out_data.last !== want.last ||
                    o_out_data.occupancy !== want.occupancy) begin
                    note_mismatch("field differs", want, o_out_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic deque_step(input t_in item);
        t_out       reply;
        logic [3:0] idx;
        int         k;
        reply      = '0;
        reply.last = 1'b1;
        case (item.func)
            F_PUSH_FRONT, F_PUSH_REAR: begin
                if (shadow_count == 5'(QUEUE_DEPTH)) begin
                    reply.status = ST_FULL;
                    refused_pushes++;
                end else begin
                    if (item.func == F_PUSH_FRONT) begin
                        shadow_head = shadow_head - 4'd1;
                        idx         = shadow_head;
                    end else begin
                        idx = shadow_head + shadow_count[3:0];
                    end
                    shadow_slot[idx] = item.value_in;
                    shadow_count     = shadow_count + 5'd1;
                    reply.status     = ST_OK;
                end
                reply.occupancy = shadow_count;
                deque_replies.push_back(reply);
            end
            F_POP_FRONT, F_POP_REAR: begin
                if (shadow_count == 5'd0) begin
                    reply.status = ST_EMPTY;
                    empty_answers++;
                end else begin
                    if (item.func == F_POP_FRONT) begin
                        idx         = shadow_head;
                        shadow_head = shadow_head + 4'd1;
                    end else begin
                        idx = shadow_head + shadow_count[3:0] - 4'd1;
                    end
                    reply.value_out = shadow_slot[idx];
                    reply.status    = ST_OK;
                    shadow_count    = shadow_count - 5'd1;
                end
                reply.occupancy = shadow_count;
                deque_replies.push_back(reply);
            end
            F_LIST: begin
                reply.occupancy = shadow_count;
                if (shadow_count == 5'd0) begin
                    reply.status = ST_EMPTY;
                    empty_answers++;
                    deque_replies.push_back(reply);
                end else begin
                    for (k = 0; k < shadow_count; k++) begin
                        idx             = shadow_head + 4'(k);
                        reply.value_out = shadow_slot[idx];
                        reply.status    = ST_OK;
                        reply.last      = (k == shadow_count - 1);
                        deque_replies.push_back(reply);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic [2:0] func, input logic signed [31:0] value);
        t_in item;
        int  gap;
        item.func     = func;
        item.value_in = value;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        ops_sent++;
        deque_step(item);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (deque_replies.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] random_job_id();
        case ($urandom_range(7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] random_push();
        return $urandom_range(1) ? F_PUSH_FRONT : F_PUSH_REAR;
    endfunction

    function automatic logic [2:0] random_pop();
        return $urandom_range(1) ? F_POP_FRONT : F_POP_REAR;
    endfunction

    task automatic test_empty_queue();
        int k;
        send_beat(F_POP_FRONT, random_job_id());
        send_beat(F_POP_REAR, random_job_id());
        send_beat(F_LIST, random_job_id());
        for (k = F_SPARE_FIRST; k <= F_SPARE_LAST; k++) begin
            send_beat(3'(k), -32'sd1);
        end
        wait_drained();
    endtask

    task automatic test_end_operations();
        send_beat(F_PUSH_FRONT, 32'sh7fffffff);
        send_beat(F_PUSH_REAR, 32'sh80000000);
        send_beat(F_PUSH_FRONT, -32'sd1);
        send_beat(F_PUSH_REAR, 32'sd0);
        send_beat(F_LIST, 32'sd0);
        send_beat(F_POP_REAR, 32'sd0);
        send_beat(F_POP_FRONT, 32'sd0);
        send_beat(F_POP_REAR, 32'sd0);
        send_beat(F_POP_FRONT, 32'sd0);
        send_beat(F_POP_FRONT, 32'sd0);
        wait_drained();
    endtask

    task automatic test_fill_to_full();
        while (shadow_count < 5'(QUEUE_DEPTH)) send_beat(random_push(), random_job_id());
        send_beat(F_PUSH_FRONT, random_job_id());
        send_beat(F_PUSH_REAR, random_job_id());
        send_beat(F_LIST, $urandom);
        while (shadow_count != 5'd0) send_beat(random_pop(), $urandom);
        send_beat(F_POP_REAR, $urandom);
        wait_drained();
    endtask

    task automatic random_beats(input int count, input int push_pct);
        int k;
        int pick;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                send_beat(3'($urandom_range(F_SPARE_LAST, F_SPARE_FIRST)), $urandom);
            end else if (pick < 10) begin
                send_beat(F_LIST, $urandom);
            end else if (pick < 10 + push_pct * 90 / 100) begin
                send_beat(random_push(), random_job_id());
            end else begin
                send_beat(random_pop(), $urandom);
            end
        end
    endtask

    task automatic test_random_mix(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        random_beats(11, 80);
        random_beats(11, 20);
        wait_drained();
    endtask

    task automatic test_output_hold_off();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_off_start;
        for (k = 0; k < 12; k++) send_beat(random_push(), random_job_id());
        send_beat(F_LIST, $urandom);
        send_beat(F_POP_FRONT, $urandom);
        wait_drained();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_in_data      <= '0;
        shadow_head    = '0;
        shadow_count   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (shadow_slot[k]) shadow_slot[k] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_end_operations();
        test_fill_to_full();
        test_random_mix(0, 0);
        test_random_mix(48, 0);
        test_random_mix(0, 48);
        test_random_mix(11, 11);
        test_output_hold_off();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d beats, checked %0d result beats, %0d refused pushes, %0d empty answers",
                 ops_sent, beats_checked, refused_pushes, empty_answers);
        $display("idle mixes: none, sender, receiver, both, plus one long output hold-off");
        if (mismatches == 0 && deque_replies.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

// ===== double_ended_queue.f =====
design/deq_pkg.sv
design/deq_ctrl.sv
design/deq_dpath.sv
design/double_ended_queue.sv
bench/tb.sv
